@@ rtl/core/drpu_pkg.sv @@
// Shared types, constants and helpers for the dead-reckoning pose update block.
package drpu_pkg;

   // CORDIC datapath: Q2.30 values with guard bits
   localparam int CordW = 34;
   typedef logic signed [CordW-1:0] cord_type;

   // Heading accumulation width (Q4.28 plus growth of the yaw increment)
   localparam int WideW = 46;
   typedef logic signed [WideW-1:0] wide_type;

   // Shared multiplier operands and product
   localparam int MulAW = 34;
   localparam int MulBW = 33;
   localparam int ProdW = MulAW + MulBW;
   typedef logic signed [MulAW-1:0] mul_a_type;
   typedef logic signed [MulBW-1:0] mul_b_type;
   typedef logic signed [ProdW-1:0] prod_type;

   typedef logic signed [31:0] word_type;

   // Arctangent table depth and index width
   localparam int AtanEntries = 30;
   localparam int IdxW = 5;
   typedef logic [IdxW-1:0] idx_type;

   // Angle constants, Q4.28
   localparam cord_type PiQ28       = 34'sd843314857;
   localparam cord_type NegPiQ28    = -34'sd843314857;
   localparam cord_type HalfPiQ28   = 34'sd421657428;
   localparam cord_type NegHalfPiQ28 = -34'sd421657428;
   localparam cord_type TwoPiQ28    = 34'sd1686629713;
   localparam wide_type TwoPiWide    = 46'sd1686629713;
   localparam wide_type NegTwoPiWide = -46'sd1686629713;

   // Reciprocal CORDIC gain, Q2.30
   localparam cord_type GainQ30 = 34'sd652032874;

   // Saturation bounds
   localparam wide_type S32Max = 46'sd2147483647;
   localparam wide_type S32Min = -46'sd2147483648;

   localparam logic [23:0] TimeStepReset = 24'd16777;

   typedef struct packed {
      cord_type cos_val;
      cord_type sin_val;
   } cordic_res_type;

   // Arctangent of 2^-i, Q2.30
   function automatic cord_type atan_lookup(input idx_type idx);
      cord_type r;
      case (idx)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         5'd24: r = 34'sd63;
         5'd25: r = 34'sd31;
         5'd26: r = 34'sd15;
         5'd27: r = 34'sd7;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Clamp to the signed 32-bit range
   function automatic word_type sat32(input wide_type v);
      word_type r;
      if (v > S32Max) begin
         r = 32'sh7fffffff;
      end else if (v < S32Min) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/drpu_mul.sv @@
// Shared signed multiplier with a registered product.
module drpu_mul (
   input  logic                 clock,
   input  drpu_pkg::mul_a_type  op_a,
   input  drpu_pkg::mul_b_type  op_b,
   output drpu_pkg::prod_type   prod
);
   import drpu_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   // Form the product; it is registered and available in the cycle after the operands
   assign prod_in = prod_type'(op_a) * prod_type'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/drpu_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin.
module drpu_cordic #(
   parameter int ITERATIONS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  drpu_pkg::word_type        angle,
   output logic                      done,
   output drpu_pkg::cordic_res_type  result
);
   import drpu_pkg::*;

   localparam int NumIter = (ITERATIONS > AtanEntries) ? AtanEntries : ITERATIONS;
   localparam idx_type LastIdx = IdxW'(NumIter - 1);

   cord_type x_ff, x_in;
   cord_type y_ff, y_in;
   cord_type z_ff, z_in;
   logic     flip_ff, flip_in;
   idx_type  cnt_ff, cnt_in;
   logic     busy_ff, busy_in;
   logic     done_ff, done_in;

   cord_type a0, a1, a2;
   logic     flip_red;
   cord_type xs, ys, at;

   // Reduce the angle to [-pi/2, pi/2]: one turn, then a half turn with sign flip
   always_comb begin
      a0 = {{(CordW - 32){angle[31]}}, angle};
      if (a0 > PiQ28) begin
         a1 = a0 - TwoPiQ28;
      end else if (a0 < NegPiQ28) begin
         a1 = a0 + TwoPiQ28;
      end else begin
         a1 = a0;
      end
      flip_red = 1'b0;
      if (a1 > HalfPiQ28) begin
         a2 = a1 - PiQ28;
         flip_red = 1'b1;
      end else if (a1 < NegHalfPiQ28) begin
         a2 = a1 + PiQ28;
         flip_red = 1'b1;
      end else begin
         a2 = a1;
      end
   end

   // Micro-rotation operands
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = atan_lookup(cnt_ff);

   // Load on start, rotate while busy
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = GainQ30;
         y_in    = '0;
         z_in    = a2 <<< 2;
         flip_in = flip_red;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CordW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastIdx) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         flip_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         flip_ff <= flip_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done           = done_ff;
   assign result.cos_val = flip_ff ? -x_ff : x_ff;
   assign result.sin_val = flip_ff ? -y_ff : y_ff;

endmodule

@@ rtl/core/dead_reckoning_pose_update.sv @@
// Dead-reckoning pose update: sequencer around a shared multiplier and an iterative CORDIC.
// Each request runs the states MULDH, SUMH, WRAP, START, CORD, MULVX, MULVY, MULDX, MULDY,
// POSY and DONE before rsp_tvalid; the next request is not taken until then, as the CORDIC loop
// (one micro-rotation per cycle) and five passes through the shared multiplier come first.
// req_tready is high only while the sequencer is idle; a finished result waits in its
// output register while the next request is taken.
// Reset (synchronous, active high) clears the pose to zero and time_step to 16777.
module dead_reckoning_pose_update #(
   parameter int CORDIC_ITERATIONS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [31:0] linear_speed, [63:32] angular_speed
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // Response: [31:0] pos_x, [63:32] pos_y, [95:64] heading
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   // time_step register
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   import drpu_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_MULDH = 12'b0000_0000_0010,
      ST_SUMH  = 12'b0000_0000_0100,
      ST_WRAP  = 12'b0000_0000_1000,
      ST_START = 12'b0000_0001_0000,
      ST_CORD  = 12'b0000_0010_0000,
      ST_MULVX = 12'b0000_0100_0000,
      ST_MULVY = 12'b0000_1000_0000,
      ST_MULDX = 12'b0001_0000_0000,
      ST_MULDY = 12'b0010_0000_0000,
      ST_POSY  = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0] time_step_ff, time_step_in;
   word_type    pose_x_ff, pose_x_in;
   word_type    pose_y_ff, pose_y_in;
   word_type    heading_ff, heading_in;
   word_type    speed_ff, speed_in;
   word_type    yaw_ff, yaw_in;
   wide_type    sum_ff, sum_in;
   cord_type    vx_ff, vx_in;
   cord_type    vy_ff, vy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   mul_a_type      op_a;
   mul_b_type      op_b;
   prod_type       prod;
   logic           cordic_start;
   logic           cordic_done;
   cordic_res_type cordic_res;

   wide_type dh;
   wide_type wrapped;
   cord_type scaled;
   cord_type dpos;
   wide_type pos_sum;

   drpu_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   drpu_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .angle  (heading_ff),
      .done   (cordic_done),
      .result (cordic_res)
   );

   assign req_tready   = (state_ff == ST_IDLE);
   assign cordic_start = (state_ff == ST_START);

   // Product slices: yaw increment, velocity, position increment
   assign dh     = prod[57:12];
   assign scaled = prod[63:30];
   assign dpos   = prod[57:24];

   // Wrap the predicted heading by one turn
   always_comb begin
      if (sum_ff > TwoPiWide) begin
         wrapped = sum_ff - TwoPiWide;
      end else if (sum_ff < NegTwoPiWide) begin
         wrapped = sum_ff + TwoPiWide;
      end else begin
         wrapped = sum_ff;
      end
   end

   // Steer the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_MULDH: begin
            op_a = {{(MulAW - 32){yaw_ff[31]}}, yaw_ff};
            op_b = {{(MulBW - 24){1'b0}}, time_step_ff};
         end
         ST_MULVX: begin
            op_a = cordic_res.cos_val;
            op_b = {{(MulBW - 32){speed_ff[31]}}, speed_ff};
         end
         ST_MULVY: begin
            op_a = cordic_res.sin_val;
            op_b = {{(MulBW - 32){speed_ff[31]}}, speed_ff};
         end
         ST_MULDX: begin
            op_a = vx_ff;
            op_b = {{(MulBW - 24){1'b0}}, time_step_ff};
         end
         ST_MULDY: begin
            op_a = vy_ff;
            op_b = {{(MulBW - 24){1'b0}}, time_step_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Position accumulation input follows the state
   always_comb begin
      if (state_ff == ST_POSY) begin
         pos_sum = {{(WideW - 32){pose_y_ff[31]}}, pose_y_ff}
                 + {{(WideW - CordW){dpos[CordW-1]}}, dpos};
      end else begin
         pos_sum = {{(WideW - 32){pose_x_ff[31]}}, pose_x_ff}
                 + {{(WideW - CordW){dpos[CordW-1]}}, dpos};
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      time_step_in = csr_we ? csr_wdata : time_step_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      heading_in   = heading_ff;
      speed_in     = speed_ff;
      yaw_in       = yaw_ff;
      sum_in       = sum_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               speed_in = req_tdata[31:0];
               yaw_in   = req_tdata[63:32];
               state_in = ST_MULDH;
            end
         end
         ST_MULDH: begin
            state_in = ST_SUMH;
         end
         ST_SUMH: begin
            sum_in   = {{(WideW - 32){heading_ff[31]}}, heading_ff} + dh;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            heading_in = sat32(wrapped);
            state_in   = ST_START;
         end
         ST_START: begin
            state_in = ST_CORD;
         end
         ST_CORD: begin
            if (cordic_done) begin
               state_in = ST_MULVX;
            end
         end
         ST_MULVX: begin
            state_in = ST_MULVY;
         end
         ST_MULVY: begin
            vx_in    = scaled;
            state_in = ST_MULDX;
         end
         ST_MULDX: begin
            vy_in    = scaled;
            state_in = ST_MULDY;
         end
         ST_MULDY: begin
            pose_x_in = sat32(pos_sum);
            state_in  = ST_POSY;
         end
         ST_POSY: begin
            pose_y_in = sat32(pos_sum);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {heading_ff, pose_y_ff, pose_x_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_step_ff <= TimeStepReset;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_step_ff <= time_step_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      speed_ff    <= speed_in;
      yaw_ff      <= yaw_in;
      sum_ff      <= sum_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ test/tb.sv @@
// Testbench for dead_reckoning_pose_update: directed table plus random odometry requests.
`timescale 1ns / 1ps

module tb;
   import drpu_pkg::*;

   localparam int CordicIters = 24;
   localparam int RotSteps    = (CordicIters > 30) ? 30 : CordicIters;
   localparam int CycleLimit  = 600000;
   localparam int PlanLen     = 25;

   localparam longint TwoPiQ28c  = 1686629713;
   localparam longint PiQ28c     = 843314857;
   localparam longint HalfPiQ28c = 421657428;
   localparam longint GainQ30c   = 652032874;

   localparam word_type WMax = 32'sh7fffffff;
   localparam word_type WMin = 32'sh80000000;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type hd;
   } pose_rec;

   // One directed row: optional time_step write, request, optional literal pose
   typedef struct packed {
      logic        cfg_en;
      logic [23:0] cfg_val;
      word_type    v;
      word_type    w;
      logic        typed;
      word_type    ex;
      word_type    ey;
      word_type    eh;
   } stim_row;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] linear_speed, [63:32] angular_speed
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // [31:0] pos_x, [63:32] pos_y, [95:64] heading
   logic        csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;

   // Predicted pose and time step
   longint pose_x = 0;
   longint pose_y = 0;
   longint pose_hd = 0;
   longint step_q24 = 16777;

   longint atan_q30 [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047,
      1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1
   };

   pose_rec pending_poses [$];
   stim_row plan [PlanLen];
   int      mismatches = 0;
   int      rsp_count = 0;
   int      burst_left = 0;
   int      cycle_count = 0;
   int      ready_hold = 0;

   dead_reckoning_pose_update #(.CORDIC_ITERATIONS(CordicIters)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Clamp to the signed 32-bit range
   function automatic longint clamp_s32(input longint v);
      if (v > longint'(WMax)) return longint'(WMax);
      if (v < longint'(WMin)) return longint'(WMin);
      return v;
   endfunction

   // Rotate the unit vector by a Q4.28 angle, return cos and sin in Q2.30
   function automatic void cordic_unit(input longint ang, output longint c, output longint s);
      longint a, x, y, z, xs, ys;
      bit     flip;
      a = ang;
      x = GainQ30c;
      y = 0;
      flip = 1'b0;
      if (a > PiQ28c) a -= TwoPiQ28c;
      else if (a < -PiQ28c) a += TwoPiQ28c;
      if (a > HalfPiQ28c) begin
         a -= PiQ28c;
         flip = 1'b1;
      end else if (a < -HalfPiQ28c) begin
         a += PiQ28c;
         flip = 1'b1;
      end
      z = a * 4;
      for (int i = 0; i < RotSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= atan_q30[i];
         end else begin
            x += ys;
            y -= xs;
            z += atan_q30[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Integrate one velocity sample into the predicted pose
   function automatic void pose_advance(input word_type v, input word_type w,
                                        output pose_rec res);
      longint vl, wl, dh, t, c, s, vx, vy;
      vl = v;
      wl = w;
      dh = (wl * step_q24) >>> 12;
      t = pose_hd;
      // wrap by one turn at most, then add the increment
      if (t + dh > TwoPiQ28c) t -= TwoPiQ28c;
      else if (t + dh < -TwoPiQ28c) t += TwoPiQ28c;
      pose_hd = clamp_s32(t + dh);
      cordic_unit(pose_hd, c, s);
      vx = (vl * c) >>> 30;
      vy = (vl * s) >>> 30;
      pose_x = clamp_s32(pose_x + ((vx * step_q24) >>> 24));
      pose_y = clamp_s32(pose_y + ((vy * step_q24) >>> 24));
      res.x = pose_x[31:0];
      res.y = pose_y[31:0];
      res.hd = pose_hd[31:0];
   endfunction

   // Pick a speed or yaw rate: mostly moderate, some tiny, some extreme or fully random
   function automatic word_type rand_rate();
      int unsigned sel;
      word_type    m;
      sel = $urandom_range(0, 9);
      case (sel)
         0: m = $urandom;
         1: case ($urandom_range(0, 4))
               0: m = WMax;
               1: m = WMin;
               2: m = 0;
               3: m = 1;
               default: m = -1;
            endcase
         2, 3: m = $urandom_range(0, 32'h0010_0000);
         default: m = $urandom_range(0, 32'h0100_0000);
      endcase
      if (sel >= 2 && $urandom_range(0, 1) == 1) m = -m;
      return m;
   endfunction

   task automatic report(input string what, input word_type got, input word_type want);
      mismatches++;
      if (mismatches <= 40)
         $display("response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
   endtask

   // Send one request in bursts with random gaps, predict at acceptance
   task automatic offer(input word_type v, input word_type w, input bit typed,
                        input pose_rec lit);
      int      gap;
      pose_rec got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata <= {w, v};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pose_advance(v, w, got);
      pending_poses.push_back(typed ? lit : got);
   endtask

   // Hold off requests until every pending pose has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_step(input logic [23:0] val);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      step_q24 = val;
   endtask

   // Stall the response side: open stretches, long stalls, random toggling
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_tready <= 1'b1;
               ready_hold <= $urandom_range(20, 200);
            end
            1: begin
               rsp_tready <= 1'b0;
               ready_hold <= $urandom_range(1, 60);
            end
            default: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
         endcase
      end
   end

   // Check each accepted response against the oldest pending pose
   always @(posedge clock) begin
      pose_rec want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_poses.size() == 0) begin
            report("response with no request pending, pos_x", rsp_tdata[31:0], 0);
         end else begin
            want = pending_poses.pop_front();
            if (rsp_tdata[31:0] !== want.x) report("pos_x", rsp_tdata[31:0], want.x);
            if (rsp_tdata[63:32] !== want.y) report("pos_y", rsp_tdata[63:32], want.y);
            if (rsp_tdata[95:64] !== want.hd) report("heading", rsp_tdata[95:64], want.hd);
         end
         rsp_count++;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("[dead_reckoning_pose_update] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned ph, k;
      logic [23:0] stp;

      plan = '{
         // after reset: zero pose
         '{1'b0, 24'd0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         // zero step freezes the pose
         '{1'b1, 24'd0, WMax, WMax, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMin, WMin, 1'b1, 32'sd0, 32'sd0, 32'sd0},
         // huge yaw step at full step: heading saturates high, then low
         '{1'b1, 24'hffffff, 32'sd0, WMax, 1'b1, 32'sd0, 32'sd0, WMax},
         '{1'b0, 24'd0, 32'sd0, WMin, 1'b1, 32'sd0, 32'sd0, WMin},
         // full speed: heading wraps back one turn, positions saturate
         '{1'b0, 24'd0, WMax, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMax, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMax, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMin, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMin, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         // default step, unit and smallest rates
         '{1'b1, 24'd16777, 32'sd65536, 32'sd65536, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, -32'sd65536, -32'sd65536, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, -32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         // about a turn per request both ways, crossing the wrap limits
         '{1'b1, 24'hffffff, 32'sh00010000, 32'sh00064000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh00010000, 32'sh00064000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh00010000, -32'sh00064000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh00010000, -32'sh00064000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         // smallest nonzero step
         '{1'b1, 24'd1, WMax, WMax, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, WMin, WMin, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         // quarter turns and eighth turns through every quadrant
         '{1'b1, 24'h800000, 32'sh7fff0000, 32'sh0003243f, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh7fff0000, 32'sh0003243f, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh7fff0000, 32'sh0003243f, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh00020000, 32'sh0001921f, 1'b0, 32'sd0, 32'sd0, 32'sd0},
         '{1'b0, 24'd0, 32'sh00020000, 32'sh0001921f, 1'b0, 32'sd0, 32'sd0, 32'sd0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      for (k = 0; k < PlanLen; k++) begin
         if (plan[k].cfg_en) write_step(plan[k].cfg_val);
         offer(plan[k].v, plan[k].w, plan[k].typed,
               '{plan[k].ex, plan[k].ey, plan[k].eh});
      end

      // random phases, one time step each
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: stp = 24'hffffff;
            1: stp = 24'($urandom_range(0, 24'hffffff));
            2: stp = 24'd0;
            3: stp = 24'($urandom_range(1, 4095));
            4: stp = 24'd1;
            default: stp = 24'd16777;
         endcase
         write_step(stp);
         for (k = 0; k < 100; k++) begin
            offer(rand_rate(), rand_rate(), 1'b0, '0);
            if ($urandom_range(0, 63) == 0) settle();
         end
      end

      // drain and give stray responses a chance to show up
      settle();
      repeat (CordicIters + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("[dead_reckoning_pose_update] OK");
      end else begin
         $display("[dead_reckoning_pose_update] ERROR");
      end
      $finish;
   end

endmodule
